### design/spo_pkg.sv
// ----------------------------------------------------------------------------
// spo_pkg
// Shared types and widths for the shape pair overlap test pipeline.
// ----------------------------------------------------------------------------
package spo_pkg;

    // Coordinate format: signed fixed point, 4 fraction bits
    localparam int COORD_W = 16;
    // Difference or sum of two coordinates
    localparam int DIFF_W  = COORD_W + 1;
    // Doubled-coordinate terms (2c - (lo + hi))
    localparam int SUM2_W  = COORD_W + 2;
    // Excess minus half-size before the floor at zero
    localparam int CLAMP_W = COORD_W + 3;
    // Unsigned squarer operand
    localparam int MAG_W   = COORD_W + 2;
    // Square and sum of two squares
    localparam int SQ_W    = 2 * MAG_W;
    localparam int ACC_W   = SQ_W + 1;

    typedef enum logic
    {
        KIND_BOX    = 1'b0,
        KIND_CIRCLE = 1'b1
    } spo_kind_t;

    typedef enum logic [1:0]
    {
        MODE_BOX_BOX,
        MODE_BOX_CIRC,
        MODE_CIRC_CIRC
    } spo_mode_t;

    // Stage 1 result: differences, doubled offsets, box-box flag
    typedef struct packed
    {
        spo_mode_t                 mode;
        logic                      bb_hit;
        logic signed [DIFF_W-1:0]  dx;
        logic signed [DIFF_W-1:0]  dy;
        logic signed [DIFF_W-1:0]  rsum;
        logic [COORD_W:0]          ux;
        logic [COORD_W:0]          uy;
        logic signed [DIFF_W-1:0]  hwx;
        logic signed [DIFF_W-1:0]  hwy;
        logic signed [COORD_W-1:0] rad;
    } spo_prep_t;

    // Stage 2 result: squarer operands
    typedef struct packed
    {
        spo_mode_t        mode;
        logic             bb_hit;
        logic [MAG_W-1:0] op0;
        logic [MAG_W-1:0] op1;
        logic [MAG_W-1:0] op2;
    } spo_clamp_t;

    // Stage 3 result: squares
    typedef struct packed
    {
        spo_mode_t       mode;
        logic            bb_hit;
        logic [SQ_W-1:0] sq0;
        logic [SQ_W-1:0] sq1;
        logic [SQ_W-1:0] sq2;
    } spo_square_t;

endpackage

### design/spo_pair_if.sv
// ----------------------------------------------------------------------------
// spo_pair_if
// Request channel carrying one pair of shapes.
// ----------------------------------------------------------------------------
interface spo_pair_if;
    import spo_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      a_kind;
    logic signed [COORD_W-1:0] a_first_x;
    logic signed [COORD_W-1:0] a_first_y;
    logic signed [COORD_W-1:0] a_second_x;
    logic signed [COORD_W-1:0] a_second_y;
    logic                      b_kind;
    logic signed [COORD_W-1:0] b_first_x;
    logic signed [COORD_W-1:0] b_first_y;
    logic signed [COORD_W-1:0] b_second_x;
    logic signed [COORD_W-1:0] b_second_y;

    modport source
    (
        output valid, a_kind, a_first_x, a_first_y, a_second_x, a_second_y,
        output b_kind, b_first_x, b_first_y, b_second_x, b_second_y,
        input  ready
    );

    modport sink
    (
        input  valid, a_kind, a_first_x, a_first_y, a_second_x, a_second_y,
        input  b_kind, b_first_x, b_first_y, b_second_x, b_second_y,
        output ready
    );

endinterface

### design/spo_result_if.sv
// ----------------------------------------------------------------------------
// spo_result_if
// Result channel carrying the overlap flag.
// ----------------------------------------------------------------------------
interface spo_result_if;

    logic valid;
    logic ready;
    logic overlap;

    modport source
    (
        output valid, overlap,
        input  ready
    );

    modport sink
    (
        input  valid, overlap,
        output ready
    );

endinterface

### design/spo_prep.sv
// ----------------------------------------------------------------------------
// spo_prep
// Stage 1: decode shape kinds, box-box interval test, coordinate differences
// and doubled-coordinate offsets of the circle centre from the box centre.
// ----------------------------------------------------------------------------
module spo_prep
(
    input  logic               clk,
    input  logic               rst_n,
    spo_pair_if.sink           pair,
    input  logic               out_ready,
    output logic               out_valid,
    output spo_pkg::spo_prep_t out_data
);
    import spo_pkg::*;

    logic      valid_reg;
    spo_prep_t data_reg;
    spo_prep_t data_next;
    logic      circ_is_a;

    logic signed [COORD_W-1:0] bx0, by0, bx1, by1;
    logic signed [COORD_W-1:0] cx, cy;
    logic signed [SUM2_W-1:0]  ddx, ddy, ndx, ndy;

    // Stage accepts when empty or when its content moves on
    assign pair.ready = !valid_reg || out_ready;

    // Box and circle roles for the mixed test
    assign circ_is_a = (spo_kind_t'(pair.a_kind) == KIND_CIRCLE);
    assign bx0 = circ_is_a ? pair.b_first_x  : pair.a_first_x;
    assign by0 = circ_is_a ? pair.b_first_y  : pair.a_first_y;
    assign bx1 = circ_is_a ? pair.b_second_x : pair.a_second_x;
    assign by1 = circ_is_a ? pair.b_second_y : pair.a_second_y;
    assign cx  = circ_is_a ? pair.a_first_x  : pair.b_first_x;
    assign cy  = circ_is_a ? pair.a_first_y  : pair.b_first_y;

    // 2c - (lo + hi), doubled coordinates
    assign ddx = (SUM2_W'(cx) + SUM2_W'(cx)) - (SUM2_W'(bx0) + SUM2_W'(bx1));
    assign ddy = (SUM2_W'(cy) + SUM2_W'(cy)) - (SUM2_W'(by0) + SUM2_W'(by1));
    assign ndx = -ddx;
    assign ndy = -ddy;

    always_comb
    begin
        // test selection
        if (spo_kind_t'(pair.a_kind) == KIND_BOX && spo_kind_t'(pair.b_kind) == KIND_BOX)
        begin
            data_next.mode = MODE_BOX_BOX;
        end
        else if (spo_kind_t'(pair.a_kind) == KIND_CIRCLE &&
                 spo_kind_t'(pair.b_kind) == KIND_CIRCLE)
        begin
            data_next.mode = MODE_CIRC_CIRC;
        end
        else
        begin
            data_next.mode = MODE_BOX_CIRC;
        end

        // closed intervals, touching counts
        data_next.bb_hit = !(pair.a_second_x < pair.b_first_x ||
                             pair.b_second_x < pair.a_first_x) &&
                           !(pair.a_second_y < pair.b_first_y ||
                             pair.b_second_y < pair.a_first_y);

        // circle pair terms
        data_next.dx   = DIFF_W'(pair.a_first_x) - DIFF_W'(pair.b_first_x);
        data_next.dy   = DIFF_W'(pair.a_first_y) - DIFF_W'(pair.b_first_y);
        data_next.rsum = DIFF_W'(pair.a_second_x) + DIFF_W'(pair.b_second_x);

        // box-circle terms
        data_next.ux  = ddx[SUM2_W-1] ? ndx[COORD_W:0] : ddx[COORD_W:0];
        data_next.uy  = ddy[SUM2_W-1] ? ndy[COORD_W:0] : ddy[COORD_W:0];
        data_next.hwx = DIFF_W'(bx1) - DIFF_W'(bx0);
        data_next.hwy = DIFF_W'(by1) - DIFF_W'(by0);
        data_next.rad = circ_is_a ? pair.a_second_x : pair.b_second_x;
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pair.ready)
        begin
            valid_reg <= pair.valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (pair.ready && pair.valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### design/spo_clamp.sv
// ----------------------------------------------------------------------------
// spo_clamp
// Stage 2: magnitudes, clamp of the centre offset by the box half-size, and
// selection of the three squarer operands for the chosen test.
// ----------------------------------------------------------------------------
module spo_clamp
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  spo_pkg::spo_prep_t  in_data,
    input  logic                out_ready,
    output logic                out_valid,
    output spo_pkg::spo_clamp_t out_data
);
    import spo_pkg::*;

    logic       valid_reg;
    spo_clamp_t data_reg;
    spo_clamp_t data_next;

    logic signed [CLAMP_W-1:0] vx, vy;
    logic [MAG_W-1:0]          ex, ey;
    logic signed [DIFF_W-1:0]  ndx, ndy, nrs;
    logic [DIFF_W-1:0]         mdx, mdy, mrs;
    logic signed [COORD_W-1:0] nrad;
    logic [COORD_W-1:0]        mrad;

    assign in_ready = !valid_reg || out_ready;

    // offset beyond the half-size, floored at zero
    assign vx = CLAMP_W'($signed({1'b0, in_data.ux})) - CLAMP_W'(in_data.hwx);
    assign vy = CLAMP_W'($signed({1'b0, in_data.uy})) - CLAMP_W'(in_data.hwy);
    assign ex = (!vx[CLAMP_W-1] && vx != '0) ? vx[MAG_W-1:0] : '0;
    assign ey = (!vy[CLAMP_W-1] && vy != '0) ? vy[MAG_W-1:0] : '0;

    // magnitudes
    assign ndx  = -in_data.dx;
    assign ndy  = -in_data.dy;
    assign nrs  = -in_data.rsum;
    assign nrad = -in_data.rad;
    assign mdx  = in_data.dx[DIFF_W-1]    ? ndx  : in_data.dx;
    assign mdy  = in_data.dy[DIFF_W-1]    ? ndy  : in_data.dy;
    assign mrs  = in_data.rsum[DIFF_W-1]  ? nrs  : in_data.rsum;
    assign mrad = in_data.rad[COORD_W-1]  ? nrad : in_data.rad;

    // operand select
    always_comb
    begin
        data_next.mode   = in_data.mode;
        data_next.bb_hit = in_data.bb_hit;
        unique case (in_data.mode)
            MODE_CIRC_CIRC:
            begin
                data_next.op0 = MAG_W'(mdx);
                data_next.op1 = MAG_W'(mdy);
                data_next.op2 = MAG_W'(mrs);
            end
            MODE_BOX_CIRC:
            begin
                data_next.op0 = ex;
                data_next.op1 = ey;
                data_next.op2 = MAG_W'({mrad, 1'b0});
            end
            default:
            begin
                data_next.op0 = '0;
                data_next.op1 = '0;
                data_next.op2 = '0;
            end
        endcase
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // doubled radius is always even
    ap_even_radius: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && data_reg.mode == MODE_BOX_CIRC |-> !data_reg.op2[0])
        else $error("box-circle radius operand not doubled");

    // box pair carries no square terms
    ap_bb_zero_ops: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && data_reg.mode == MODE_BOX_BOX |->
        data_reg.op0 == '0 && data_reg.op1 == '0 && data_reg.op2 == '0)
        else $error("box pair with non-zero operands");

endmodule

### design/spo_square.sv
// ----------------------------------------------------------------------------
// spo_square
// Stage 3: three parallel squarers.
// ----------------------------------------------------------------------------
module spo_square
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  spo_pkg::spo_clamp_t  in_data,
    input  logic                 out_ready,
    output logic                 out_valid,
    output spo_pkg::spo_square_t out_data
);
    import spo_pkg::*;

    logic        valid_reg;
    spo_square_t data_reg;
    spo_square_t data_next;

    assign in_ready = !valid_reg || out_ready;

    // squares
    always_comb
    begin
        data_next.mode   = in_data.mode;
        data_next.bb_hit = in_data.bb_hit;
        data_next.sq0    = in_data.op0 * in_data.op0;
        data_next.sq1    = in_data.op1 * in_data.op1;
        data_next.sq2    = in_data.op2 * in_data.op2;
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### design/spo_compare.sv
// ----------------------------------------------------------------------------
// spo_compare
// Stage 4: sum of squared offsets against squared radius, or the box-box
// flag for a box pair; final flag into the output register.
// ----------------------------------------------------------------------------
module spo_compare
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  spo_pkg::spo_square_t in_data,
    spo_result_if.source         result
);
    import spo_pkg::*;

    logic             valid_reg;
    logic             hit_reg;
    logic             hit_next;
    logic [ACC_W-1:0] dist_sum;

    assign in_ready = !valid_reg || result.ready;

    // strict compare for both round tests
    assign dist_sum = ACC_W'(in_data.sq0) + ACC_W'(in_data.sq1);

    always_comb
    begin
        if (in_data.mode == MODE_BOX_BOX)
        begin
            hit_next = in_data.bb_hit;
        end
        else
        begin
            hit_next = dist_sum < ACC_W'(in_data.sq2);
        end
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // result
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            hit_reg <= hit_next;
        end
    end

    assign result.valid   = valid_reg;
    assign result.overlap = hit_reg;

    // an item taken in always shows up at the output next cycle
    ap_taken_shows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> valid_reg)
        else $error("accepted request lost in output stage");

    // empty output register never back-pressures
    ap_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg |-> in_ready)
        else $error("output stage stalls while empty");

endmodule

### design/shape_pair_overlap_test.sv
// ----------------------------------------------------------------------------
// shape_pair_overlap_test
// Overlap test of two 2D shapes (box or circle each), four-stage pipeline.
// ----------------------------------------------------------------------------
// Pipeline: four register stages (prep, clamp, square, compare), passed in
//   order. Throughput: one request per cycle while result.ready is high, set
//   by the single pass through the stages (kind decode, clamp, squarers,
//   compare); no state between requests.
// Reset: rst_n clears the stage valid bits only; the payload is not reset.
// ----------------------------------------------------------------------------
module shape_pair_overlap_test
(
    input  logic         clk,
    input  logic         rst_n,
    spo_pair_if.sink     pair,
    spo_result_if.source result
);
    import spo_pkg::*;

    logic        prep_valid, prep_ready;
    spo_prep_t   prep_data;
    logic        clamp_valid, clamp_ready;
    spo_clamp_t  clamp_data;
    logic        square_valid, square_ready;
    spo_square_t square_data;

    // stage 1
    spo_prep u_prep
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pair      (pair),
        .out_ready (prep_ready),
        .out_valid (prep_valid),
        .out_data  (prep_data)
    );

    // stage 2
    spo_clamp u_clamp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prep_valid),
        .in_ready  (prep_ready),
        .in_data   (prep_data),
        .out_ready (clamp_ready),
        .out_valid (clamp_valid),
        .out_data  (clamp_data)
    );

    // stage 3
    spo_square u_square
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (clamp_valid),
        .in_ready  (clamp_ready),
        .in_data   (clamp_data),
        .out_ready (square_ready),
        .out_valid (square_valid),
        .out_data  (square_data)
    );

    // stage 4
    spo_compare u_compare
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (square_valid),
        .in_ready (square_ready),
        .in_data  (square_data),
        .result   (result)
    );

endmodule

### sim/shape_pair_overlap_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shape_pair_overlap_checker
// Watches the pair and result channels. Works out the overlap flag of every
// accepted request and compares it, in order, with the flags that come out.
// ----------------------------------------------------------------------------
module shape_pair_overlap_checker
(
    input  logic  clk,
    input  logic  rst_n,
    spo_pair_if   pair,
    spo_result_if result,
    output int    mismatches,
    output int    pending,
    output int    checked,
    output int    hits
);
    import spo_pkg::*;

    localparam int REPORT_LIMIT = 10;

    logic overlap_due[$];
    logic want_flag;
    int   n_mismatch = 0;
    int   n_pending  = 0;
    int   n_checked  = 0;
    int   n_hits     = 0;

    assign mismatches = n_mismatch;
    assign pending    = n_pending;
    assign checked    = n_checked;
    assign hits       = n_hits;

    function automatic longint magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Offset of the centre beyond the box half-size on one axis, floored at
    // zero; doubled coordinates keep the box centre exact
    function automatic longint axis_excess(input longint c, input longint lo,
                                           input longint hi);
        longint over;
        over = magnitude(2 * c - (lo + hi)) - (hi - lo);
        return (over > 0) ? over : 0;
    endfunction

    // Box given by corners, circle by centre and radius; the radius is
    // doubled to match the doubled offsets
    function automatic logic box_circle_hit(input longint bx0, by0, bx1, by1,
                                            input longint cx, cy, r);
        longint ex;
        longint ey;
        longint reach;
        ex    = axis_excess(cx, bx0, bx1);
        ey    = axis_excess(cy, by0, by1);
        reach = 2 * magnitude(r);
        return (ex * ex + ey * ey) < (reach * reach);
    endfunction

    function automatic logic predict_overlap(input logic ka,
                                             input longint a0, a1, a2, a3,
                                             input logic kb,
                                             input longint b0, b1, b2, b3);
        longint dx;
        longint dy;
        longint rsum;
        dx   = a0 - b0;
        dy   = a1 - b1;
        rsum = a2 + b2;
        if (ka == KIND_BOX && kb == KIND_BOX)
            // closed intervals: touching counts
            return !(a2 < b0 || b2 < a0) && !(a3 < b1 || b3 < a1);
        else if (ka == KIND_BOX)
            return box_circle_hit(a0, a1, a2, a3, b0, b1, b2);
        else if (kb == KIND_BOX)
            return box_circle_hit(b0, b1, b2, b3, a0, a1, a2);
        else
            // signed radius sum, strict compare
            return (dx * dx + dy * dy) < (rsum * rsum);
    endfunction

    task automatic note_mismatch(input string what, input logic want, input logic got);
        n_mismatch++;
        if (n_mismatch <= REPORT_LIMIT)
            $display("MISMATCH at result %0d: %s (expected %b, got %b)",
                     n_checked, what, want, got);
    endtask

    // Predict on each request, compare on each result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pair.valid && pair.ready)
                overlap_due.push_back(predict_overlap(
                    pair.a_kind, pair.a_first_x, pair.a_first_y,
                    pair.a_second_x, pair.a_second_y,
                    pair.b_kind, pair.b_first_x, pair.b_first_y,
                    pair.b_second_x, pair.b_second_y));
            if (result.valid && result.ready)
            begin
                if (overlap_due.size() == 0)
                    note_mismatch("result with no request waiting", 1'bx, result.overlap);
                else
                begin
                    want_flag = overlap_due.pop_front();
                    if (result.overlap !== want_flag)
                        note_mismatch("overlap flag", want_flag, result.overlap);
                end
                n_checked++;
                if (result.overlap === 1'b1)
                    n_hits++;
            end
            n_pending = overlap_due.size();
        end
    end

endmodule

### sim/shape_pair_overlap_test_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shape_pair_overlap_test_tb
// Drives pairs of boxes and circles into the overlap test with random gaps
// and output stalls, including one long output hold-off; the checker beside
// the block predicts every flag and the top gives the verdict.
// ----------------------------------------------------------------------------
module shape_pair_overlap_test_tb;
    import spo_pkg::*;

    localparam int RANDOM_ITEMS  = 730;
    localparam int IDLE_PCT      = 30;
    // sender runs without gaps over this range of requests
    localparam int TX_QUIET_FROM = 450;
    localparam int TX_QUIET_TO   = 550;
    // receiver cycles, counted from reset release
    localparam int HOLD_AT       = 300;
    localparam int HOLD_LEN      = 120;
    localparam int RX_QUIET_FROM = 900;
    localparam int RX_QUIET_TO   = 1100;
    localparam int DRAIN_CYCLES  = 12;

    logic clk;
    logic rst_n;
    int   n_sent = 0;
    int   n_box_box = 0;
    int   n_box_circle = 0;
    int   n_circle_circle = 0;
    int   mismatches;
    int   pending;
    int   checked;
    int   hits;

    spo_pair_if   pair_ch();
    spo_result_if result_ch();

    shape_pair_overlap_test DUT
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .pair   (pair_ch),
        .result (result_ch)
    );

    shape_pair_overlap_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .pair       (pair_ch),
        .result     (result_ch),
        .mismatches (mismatches),
        .pending    (pending),
        .checked    (checked),
        .hits       (hits)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Reset, once
    initial
    begin
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Run limit
    initial
    begin
        #200us;
        $display("Timed out with %0d results outstanding", pending);
        $display("RESULT: ERROR");
        $finish;
    end

    // Offer one request, with random gaps ahead of it, and wait for acceptance
    task automatic send_pair(input spo_kind_t ak, input int a0, a1, a2, a3,
                             input spo_kind_t bk, input int b0, b1, b2, b3);
        if (n_sent < TX_QUIET_FROM || n_sent >= TX_QUIET_TO)
            while ($urandom_range(99) < IDLE_PCT)
            begin
                pair_ch.valid <= 1'b0;
                @(posedge clk);
            end
        pair_ch.valid      <= 1'b1;
        pair_ch.a_kind     <= ak;
        pair_ch.a_first_x  <= COORD_W'(a0);
        pair_ch.a_first_y  <= COORD_W'(a1);
        pair_ch.a_second_x <= COORD_W'(a2);
        pair_ch.a_second_y <= COORD_W'(a3);
        pair_ch.b_kind     <= bk;
        pair_ch.b_first_x  <= COORD_W'(b0);
        pair_ch.b_first_y  <= COORD_W'(b1);
        pair_ch.b_second_x <= COORD_W'(b2);
        pair_ch.b_second_y <= COORD_W'(b3);
        @(posedge clk);
        while (!pair_ch.ready)
            @(posedge clk);
        n_sent++;
        if (ak == KIND_BOX && bk == KIND_BOX)
            n_box_box++;
        else if (ak == KIND_CIRCLE && bk == KIND_CIRCLE)
            n_circle_circle++;
        else
            n_box_circle++;
    endtask

    function automatic int near(input int centre, input int spread);
        return centre + int'($urandom_range(2 * spread)) - spread;
    endfunction

    // One shape: raw 16-bit fields, or a shape near (cx, cy) so that
    // overlaps and misses both turn up
    task automatic random_shape(input int cx, input int cy, input bit raw,
                                output spo_kind_t k, output int f0, f1, f2, f3);
        int tmp;
        k = spo_kind_t'($urandom_range(1));
        if (raw)
        begin
            f0 = $urandom_range(65535);
            f1 = $urandom_range(65535);
            f2 = $urandom_range(65535);
            f3 = $urandom_range(65535);
        end
        else if (k == KIND_BOX)
        begin
            f0 = near(cx, 800);
            f1 = near(cy, 800);
            f2 = f0 + int'($urandom_range(1200));
            f3 = f1 + int'($urandom_range(1200));
            // occasional inverted box
            if ($urandom_range(9) == 0)
            begin
                tmp = f0;
                f0  = f2;
                f2  = tmp;
            end
            if ($urandom_range(9) == 0)
            begin
                tmp = f1;
                f1  = f3;
                f3  = tmp;
            end
        end
        else
        begin
            f0 = near(cx, 800);
            f1 = near(cy, 800);
            f2 = $urandom_range(1200);
            if ($urandom_range(19) == 0)
                f2 = -f2;
            // unused field of a circle
            f3 = $urandom_range(65535);
        end
    endtask

    // Stimulus
    initial
    begin
        spo_kind_t ak;
        spo_kind_t bk;
        int        a[4];
        int        b[4];
        int        cx;
        int        cy;
        bit        raw;

        pair_ch.valid      <= 1'b0;
        pair_ch.a_kind     <= KIND_BOX;
        pair_ch.a_first_x  <= '0;
        pair_ch.a_first_y  <= '0;
        pair_ch.a_second_x <= '0;
        pair_ch.a_second_y <= '0;
        pair_ch.b_kind     <= KIND_BOX;
        pair_ch.b_first_x  <= '0;
        pair_ch.b_first_y  <= '0;
        pair_ch.b_second_x <= '0;
        pair_ch.b_second_y <= '0;
        wait (rst_n === 1'b1);
        @(posedge clk);

        // Box against box: overlap, shared edge, one step apart, shared corner
        send_pair(KIND_BOX, 0, 0, 100, 100, KIND_BOX, 50, 50, 150, 150);
        send_pair(KIND_BOX, 0, 0, 100, 100, KIND_BOX, 100, 0, 200, 100);
        send_pair(KIND_BOX, 0, 0, 100, 100, KIND_BOX, 101, 0, 200, 100);
        send_pair(KIND_BOX, 0, 0, 100, 100, KIND_BOX, 100, 100, 200, 200);
        // inverted box is taken as written
        send_pair(KIND_BOX, 100, 100, 0, 0, KIND_BOX, 50, 50, 60, 60);
        // full-range box against a point box at the far corner
        send_pair(KIND_BOX, -32768, -32768, 32767, 32767,
                  KIND_BOX, 32767, 32767, 32767, 32767);
        // Circle against circle: tangent misses, one step closer hits
        send_pair(KIND_CIRCLE, 0, 0, 50, 0, KIND_CIRCLE, 100, 0, 50, 0);
        send_pair(KIND_CIRCLE, 0, 0, 50, -1, KIND_CIRCLE, 99, 0, 50, 32767);
        // negative radii: the signed sum is squared
        send_pair(KIND_CIRCLE, 0, 0, -50, 0, KIND_CIRCLE, 99, 0, -50, 0);
        send_pair(KIND_CIRCLE, 0, 0, 50, 0, KIND_CIRCLE, 1, 0, -50, 0);
        send_pair(KIND_CIRCLE, -32768, -32768, 32767, -32768,
                  KIND_CIRCLE, 32767, 32767, 32767, 32767);
        // Box against circle: tangent side, hit, corner distance
        send_pair(KIND_BOX, 0, 0, 100, 100, KIND_CIRCLE, 150, 50, 50, 0);
        send_pair(KIND_BOX, 0, 0, 100, 100, KIND_CIRCLE, 150, 50, 51, 0);
        send_pair(KIND_BOX, 0, 0, 100, 100, KIND_CIRCLE, 130, 140, 50, 0);
        send_pair(KIND_BOX, 0, 0, 100, 100, KIND_CIRCLE, 130, 140, 51, -1);
        // circle first, box second
        send_pair(KIND_CIRCLE, 150, 50, 51, 12345, KIND_BOX, 0, 0, 100, 100);
        send_pair(KIND_CIRCLE, 150, 50, 50, -12345, KIND_BOX, 0, 0, 100, 100);
        // zero radius inside the box: strict compare gives a miss
        send_pair(KIND_BOX, 0, 0, 100, 100, KIND_CIRCLE, 50, 50, 0, 0);
        // negative radius uses its magnitude
        send_pair(KIND_BOX, 0, 0, 100, 100, KIND_CIRCLE, 150, 50, -51, 0);
        // inverted box against a circle
        send_pair(KIND_BOX, 100, 100, 0, 0, KIND_CIRCLE, 200, 50, 60, 0);
        send_pair(KIND_CIRCLE, -32768, 32767, -32768, 0,
                  KIND_BOX, -32768, -32768, 32767, 32767);
        send_pair(KIND_BOX, 32767, 32767, -32768, -32768,
                  KIND_CIRCLE, 32767, -32768, 32767, 32767);

        // Random pairs
        repeat (RANDOM_ITEMS)
        begin
            cx  = near(0, 30000);
            cy  = near(0, 30000);
            raw = ($urandom_range(3) == 0);
            random_shape(cx, cy, raw, ak, a[0], a[1], a[2], a[3]);
            random_shape(cx, cy, raw, bk, b[0], b[1], b[2], b[3]);
            send_pair(ak, a[0], a[1], a[2], a[3], bk, b[0], b[1], b[2], b[3]);
        end
        pair_ch.valid <= 1'b0;

        // Drain
        @(posedge clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d pair tests: %0d box-box, %0d box-circle, %0d circle-circle",
                 checked, n_box_box, n_box_circle, n_circle_circle);
        $display("%0d overlapping, %0d clear; output held off %0d cycles once; %0d mismatches",
                 hits, checked - hits, HOLD_LEN, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Result acceptance: random stalls, one long hold-off, one stall-free stretch
    initial
    begin
        int cycle;
        cycle = 0;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            cycle++;
            if (cycle >= HOLD_AT && cycle < HOLD_AT + HOLD_LEN)
                result_ch.ready <= 1'b0;
            else if (cycle >= RX_QUIET_FROM && cycle < RX_QUIET_TO)
                result_ch.ready <= 1'b1;
            else
                result_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

endmodule
